// ----- design/pre_pkg.sv -----
`timescale 1ns / 1ps
// pre_pkg: shared types and constants for the power residue edge test.
// Holds the control word layout, step and condition codes, and the microcode ROM.
// No dependencies.
package pre_pkg;

	localparam int unsigned VTX_W  = 16;
	localparam int unsigned EXP_W  = 16;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned PC_W   = 4;
	localparam int unsigned COND_W = 4;

	// config register indexes
	localparam logic [IDX_W-1:0] REG_MODULUS  = 2'd0;
	localparam logic [IDX_W-1:0] REG_EXPONENT = 2'd1;

	// sequencer steps
	localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] ST_CHECK = 4'd1;
	localparam logic [PC_W-1:0] ST_LOOP  = 4'd2;
	localparam logic [PC_W-1:0] ST_EXP   = 4'd3;
	localparam logic [PC_W-1:0] ST_EXPB  = 4'd4;
	localparam logic [PC_W-1:0] ST_MSET  = 4'd5;
	localparam logic [PC_W-1:0] ST_MRUN  = 4'd6;
	localparam logic [PC_W-1:0] ST_MWB   = 4'd7;
	localparam logic [PC_W-1:0] ST_SSET  = 4'd8;
	localparam logic [PC_W-1:0] ST_SRUN  = 4'd9;
	localparam logic [PC_W-1:0] ST_SWB   = 4'd10;
	localparam logic [PC_W-1:0] ST_CMP   = 4'd11;
	localparam logic [PC_W-1:0] ST_NEXTI = 4'd12;
	localparam logic [PC_W-1:0] ST_OUT   = 4'd13;
	localparam logic [PC_W-1:0] ST_RET   = 4'd14;

	// jump conditions: taken -> target, else fall through
	localparam logic [COND_W-1:0] C_NEXT        = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
	localparam logic [COND_W-1:0] C_NO_INPUT    = 4'd2;
	localparam logic [COND_W-1:0] C_RANGE_ERR   = 4'd3;
	localparam logic [COND_W-1:0] C_I_GE_M      = 4'd4;
	localparam logic [COND_W-1:0] C_REXP_ZERO   = 4'd5;
	localparam logic [COND_W-1:0] C_REXP_EVEN   = 4'd6;
	localparam logic [COND_W-1:0] C_MUL_MORE    = 4'd7;
	localparam logic [COND_W-1:0] C_MATCH       = 4'd8;
	localparam logic [COND_W-1:0] C_OUT_BLOCKED = 4'd9;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
		logic              op_check;     // range check, difference, i = 1
		logic              op_init_pow;  // base = i, acc = 1, r = exponent
		logic              op_mul_acc;   // start acc * base
		logic              op_mul_base;  // start base * base
		logic              op_mul_step;  // one shift-add-reduce step
		logic              op_wb_acc;    // acc = product
		logic              op_wb_base;   // base = product, r >>= 1
		logic              op_set_hit;
		logic              op_inc_i;
		logic              op_out;       // load output register
	} ctrl_t;

	function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '0;
		case (pc)
			ST_IDLE: begin
				w.cond = C_NO_INPUT; w.target = ST_IDLE;
			end
			ST_CHECK: begin
				w.op_check = 1'b1; w.cond = C_RANGE_ERR; w.target = ST_OUT;
			end
			ST_LOOP: begin
				w.op_init_pow = 1'b1; w.cond = C_I_GE_M; w.target = ST_OUT;
			end
			ST_EXP: begin
				w.cond = C_REXP_ZERO; w.target = ST_CMP;
			end
			ST_EXPB: begin
				w.cond = C_REXP_EVEN; w.target = ST_SSET;
			end
			ST_MSET: begin
				w.op_mul_acc = 1'b1;
			end
			ST_MRUN: begin
				w.op_mul_step = 1'b1; w.cond = C_MUL_MORE; w.target = ST_MRUN;
			end
			ST_MWB: begin
				w.op_wb_acc = 1'b1;
			end
			ST_SSET: begin
				w.op_mul_base = 1'b1;
			end
			ST_SRUN: begin
				w.op_mul_step = 1'b1; w.cond = C_MUL_MORE; w.target = ST_SRUN;
			end
			ST_SWB: begin
				w.op_wb_base = 1'b1; w.cond = C_ALWAYS; w.target = ST_EXP;
			end
			ST_CMP: begin
				w.op_set_hit = 1'b1; w.cond = C_MATCH; w.target = ST_OUT;
			end
			ST_NEXTI: begin
				w.op_inc_i = 1'b1; w.cond = C_ALWAYS; w.target = ST_LOOP;
			end
			ST_OUT: begin
				w.op_out = 1'b1; w.cond = C_OUT_BLOCKED; w.target = ST_OUT;
			end
			ST_RET: begin
				w.cond = C_ALWAYS; w.target = ST_IDLE;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- design/power_residue_edge_test.sv -----
`timescale 1ns / 1ps
// Work: up to m-1 candidates per input, each tested by square-and-multiply over
//   the exponent bits, stopping at the first match; an out-of-range pair skips
//   the search. MW is the datapath width (16 at default).
// Throughput: one word at a time; the next input is taken once the result is in the
//   output register. The bit-serial modular multiplier sets it.
// Reset (arst_n low, async): sequencer to idle, output empty, modulus = 2, exponent = 2.
module power_residue_edge_test
	import pre_pkg::*;
#(
	parameter int unsigned MODULUS_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	// config write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [15:0] first_vertex, [31:16] second_vertex
	// result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [0] adjacent, [7:1] zero
	output logic             m_tuser    // [0] range_error
);

	// datapath width: modulus is a 16-bit field, further masked by MODULUS_BITS
	localparam int unsigned MW    = (MODULUS_BITS < CFG_W) ? MODULUS_BITS : CFG_W;
	localparam int unsigned CNT_W = $clog2(MW + 1);

	// config registers
	logic [MW-1:0]    modulus_q;
	logic [EXP_W-1:0] exponent_q;

	// sequencer
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	ctrl_t           cw;
	logic            take;

	// datapath
	logic [VTX_W-1:0] a_q, b_q;
	logic [MW-1:0]    d_q, neg_q;     // difference and its negative mod m
	logic [MW-1:0]    i_q;            // candidate
	logic [MW-1:0]    base_q, acc_q;  // square-and-multiply state
	logic [EXP_W-1:0] rexp_q;
	logic [MW-1:0]    x_q, y_q, prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hit_q, err_q;

	logic             m_tvalid_q;
	logic             adj_q;
	logic             rerr_q;

	logic             s_fire;
	logic             range_err;
	logic             match;
	logic             out_blocked;
	logic [VTX_W-1:0] m_wide;
	logic [VTX_W-1:0] diff;
	logic [MW+1:0]    m_ext;
	logic [MW+1:0]    step_sum, step_r1, step_r2;

	assign cfg_ready   = 1'b1;
	assign s_tready    = (pc_q == ST_IDLE);
	assign s_fire      = s_tvalid && s_tready;
	assign out_blocked = m_tvalid_q && !m_tready;

	assign m_wide    = VTX_W'(modulus_q);
	assign range_err = (a_q >= m_wide) || (b_q >= m_wide);
	// a - b mod m; both are below m when this is used
	assign diff      = (a_q >= b_q) ? (a_q - b_q) : (m_wide - (b_q - a_q));

	assign match     = (acc_q == d_q) || (acc_q == neg_q);

	// interleaved modular multiply: prod = 2*prod + bit*y, then at most two subtracts of m
	assign m_ext    = {2'b00, modulus_q};
	assign step_sum = {1'b0, prod_q, 1'b0} + (x_q[MW-1] ? {2'b00, y_q} : '0);
	assign step_r1  = (step_sum >= m_ext) ? (step_sum - m_ext) : step_sum;
	assign step_r2  = (step_r1 >= m_ext) ? (step_r1 - m_ext) : step_r1;

	// microcode fetch and branch
	always_comb begin
		cw = rom_word(pc_q);
		case (cw.cond)
			C_NEXT:        take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_NO_INPUT:    take = !s_fire;
			C_RANGE_ERR:   take = range_err;
			C_I_GE_M:      take = (i_q >= modulus_q);
			C_REXP_ZERO:   take = (rexp_q == '0);
			C_REXP_EVEN:   take = !rexp_q[0];
			C_MUL_MORE:    take = (cnt_q != CNT_W'(1));
			C_MATCH:       take = match;
			C_OUT_BLOCKED: take = out_blocked;
			default:       take = 1'b1;
		endcase
		pc_d = take ? cw.target : (pc_q + PC_W'(1));
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
			modulus_q  <= MW'(2);
			exponent_q <= EXP_W'(2);
		end else begin
			pc_q <= pc_d;
			if (cw.op_out && !out_blocked) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cw.op_mul_acc || cw.op_mul_base) begin
				cnt_q <= CNT_W'(MW);
			end else if (cw.op_mul_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_MODULUS:  modulus_q  <= cfg_data[MW-1:0];
					REG_EXPONENT: exponent_q <= cfg_data;
					default:      ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			a_q <= s_tdata[15:0];
			b_q <= s_tdata[31:16];
		end
		if (cw.op_check) begin
			d_q   <= diff[MW-1:0];
			neg_q <= modulus_q - diff[MW-1:0];
			i_q   <= MW'(1);
			hit_q <= 1'b0;
			err_q <= range_err;
		end
		if (cw.op_init_pow) begin
			base_q <= i_q;
			acc_q  <= MW'(1);
			rexp_q <= exponent_q;
		end
		if (cw.op_mul_acc || cw.op_mul_base) begin
			x_q    <= cw.op_mul_acc ? acc_q : base_q;
			y_q    <= base_q;
			prod_q <= '0;
		end else if (cw.op_mul_step) begin
			x_q    <= {x_q[MW-2:0], 1'b0};
			prod_q <= step_r2[MW-1:0];
		end
		if (cw.op_wb_acc) begin
			acc_q <= prod_q;
		end
		if (cw.op_wb_base) begin
			base_q <= prod_q;
			rexp_q <= {1'b0, rexp_q[EXP_W-1:1]};
		end
		if (cw.op_set_hit) begin
			hit_q <= match;
		end
		if (cw.op_inc_i) begin
			i_q <= i_q + MW'(1);
		end
		if (cw.op_out && !out_blocked) begin
			adj_q  <= hit_q;
			rerr_q <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0000000, adj_q};
	assign m_tuser  = rerr_q;

	// an accepted word always starts the range check next
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> pc_q == ST_CHECK)
		else $error("accepted word did not enter range check");

	// a result never claims both an edge and a range error
	a_exclusive_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(adj_q && rerr_q))
		else $error("adjacent and range_error both set");

	// multiplier steps only run with bits left to consume
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_MRUN || pc_q == ST_SRUN) |-> cnt_q != '0)
		else $error("multiplier step with empty count");

endmodule
